[rtl/cva_pkg.sv]
// ----------------------------------------------------------------------------
// cva_pkg
// Shared widths, register indexes and types for the chi-squared veto
// accumulator.
// ----------------------------------------------------------------------------
package cva_pkg;

  // sample and register widths
  localparam int SMP_W      = 24;
  localparam int SCALE_W    = 24;
  localparam int INV_W      = 16;
  localparam int FRAC_W     = 16;
  localparam int SUM_W      = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // difference in units of 2^-16: bin * 2^16 - full * inv, fits 41 bits signed
  localparam int T_W = SMP_W + INV_W + 1;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INV   = CFG_IDX_W'(1);

  // register reset values
  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(65536);
  localparam logic [INV_W-1:0]   INV_RST   = INV_W'(4096);

  // one classified item handed from front to back
  typedef struct packed {
    logic signed [T_W-1:0] t_re;
    logic signed [T_W-1:0] t_im;
    logic                  last;
  } item_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

endpackage

[rtl/chisq_veto_accumulator.sv]
// Throughput: one bin per cycle while no stalled result holds the pipeline;
// the front, queue and back pipeline each move one item a cycle, and the
// accumulator closes one bin sum per cycle.
// Reset: synchronous, active low; clears the accumulator, queue and stage
// valids, and sets scale to 1.0 and inv_bin_count to 1/16.
// ----------------------------------------------------------------------------
// chisq_veto_accumulator
// Chi-squared veto accumulation over the frequency bins of one time sample,
// with a register write port, a front stage, a queue and a back pipeline.
// ----------------------------------------------------------------------------
module chisq_veto_accumulator
  import cva_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
)(
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [SMP_W-1:0] in_full_re,
  input  logic signed [SMP_W-1:0] in_full_im,
  input  logic signed [SMP_W-1:0] in_bin_re,
  input  logic signed [SMP_W-1:0] in_bin_im,
  input  logic                    in_last_bin,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [SUM_W-1:0]        out_chisq_value,
  output logic                    out_saturated,
  // register write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  logic [SCALE_W-1:0] scale_r, scale_nxt;
  logic [INV_W-1:0]   inv_r, inv_nxt;
  q_stat_t            q_stat;
  logic               push, pop;
  item_t              push_item, head;

  // register writes, unknown indexes ignored
  assign cfg_ready = 1'b1;

  always_comb begin
    scale_nxt = scale_r;
    inv_nxt   = inv_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCALE: scale_nxt = cfg_data[SCALE_W-1:0];
        REG_INV:   inv_nxt   = cfg_data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RST;
      inv_r   <= INV_RST;
    end else begin
      scale_r <= scale_nxt;
      inv_r   <= inv_nxt;
    end
  end

  // front: accept and form differences
  cva_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_full_re    (in_full_re),
    .in_full_im    (in_full_im),
    .in_bin_re     (in_bin_re),
    .in_bin_im     (in_bin_im),
    .in_last_bin   (in_last_bin),
    .inv_bin_count (inv_r),
    .q_stat        (q_stat),
    .push          (push),
    .push_item     (push_item)
  );

  // queue between front and back
  cva_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // back: scale, square, accumulate, emit
  cva_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .scale           (scale_r),
    .head            (head),
    .q_stat          (q_stat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_chisq_value (out_chisq_value),
    .out_saturated   (out_saturated)
  );

endmodule

[rtl/cva_front.sv]
// ----------------------------------------------------------------------------
// cva_front
// Input stage: accepts one bin sample per transfer, forms the unscaled
// differences bin * 2^16 - full * inv_bin_count and pushes them to the queue.
// ----------------------------------------------------------------------------
module cva_front
  import cva_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [SMP_W-1:0] in_full_re,
  input  logic signed [SMP_W-1:0] in_full_im,
  input  logic signed [SMP_W-1:0] in_bin_re,
  input  logic signed [SMP_W-1:0] in_bin_im,
  input  logic                    in_last_bin,
  input  logic [INV_W-1:0]        inv_bin_count,
  input  q_stat_t                 q_stat,
  output logic                    push,
  output item_t                   push_item
);

  logic  f_valid_r, f_valid_nxt;
  item_t item_r, item_nxt;
  logic  accept;
  logic signed [INV_W:0] inv_s;
  logic signed [T_W-1:0] full_re_x;
  logic signed [T_W-1:0] full_im_x;
  logic signed [T_W-1:0] inv_x;

  // handshake: hold while the queue cannot take the staged item
  assign in_stall = f_valid_r & q_stat.full;
  assign accept   = in_valid & ~in_stall;
  assign push     = f_valid_r & ~q_stat.full;
  assign inv_s    = $signed({1'b0, inv_bin_count});

  // operands sign extended to the full difference width
  assign full_re_x = T_W'(in_full_re);
  assign full_im_x = T_W'(in_full_im);
  assign inv_x     = T_W'(inv_s);

  // difference in units of 2^-16
  always_comb begin
    item_nxt.t_re = T_W'($signed({in_bin_re, {FRAC_W{1'b0}}}))
                  - full_re_x * inv_x;
    item_nxt.t_im = T_W'($signed({in_bin_im, {FRAC_W{1'b0}}}))
                  - full_im_x * inv_x;
    item_nxt.last = in_last_bin;
  end

  always_comb begin
    f_valid_nxt = f_valid_r;
    if (accept) begin
      f_valid_nxt = 1'b1;
    end else if (push) begin
      f_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign push_item = item_r;

endmodule

[rtl/cva_queue.sv]
// ----------------------------------------------------------------------------
// cva_queue
// Short first-in first-out queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module cva_queue
  import cva_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
)(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  item_t   push_item,
  input  logic    pop,
  output item_t   head,
  output q_stat_t q_stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign q_stat.full      = (count_r == CW'(DEPTH));
  assign q_stat.not_empty = (count_r != '0);
  assign head             = mem_r[rd_ptr_r];

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[rtl/cva_back.sv]
// ----------------------------------------------------------------------------
// cva_back
// Execution pipeline: scales and rounds the differences, clips to 24 bits,
// squares, sums and accumulates; emits the sum on the last bin.
// ----------------------------------------------------------------------------
module cva_back
  import cva_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [SCALE_W-1:0] scale,
  input  item_t              head,
  input  q_stat_t            q_stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SUM_W-1:0]   out_chisq_value,
  output logic               out_saturated
);

  localparam int HI_W  = T_W - FRAC_W;
  localparam int PH_W  = HI_W + SCALE_W;
  localparam int PL_W  = FRAC_W + SCALE_W;
  localparam int R_W   = PH_W + 1;
  localparam int D_W   = SMP_W;
  localparam int SQ_W  = 2 * D_W;
  localparam logic [PL_W:0]  ROUND_K = (PL_W + 1)'(64'h8000_0000);
  localparam logic [D_W-1:0] D_POS   = D_W'((64'd1 << (D_W - 1)) - 64'd1);
  localparam logic [D_W-1:0] D_NEG   = D_W'(64'd1 << (D_W - 1));

  logic en;

  // stage valids and flags
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic s1_last_r, s2_last_r, s3_last_r, s4_last_r;
  logic s2_sat_r, s3_sat_r, s4_sat_r;

  // stage payloads, one lane per component
  logic signed [T_W-1:0] t_in  [2];
  logic [T_W-1:0]        mag   [2];
  logic [PH_W-1:0]       s1_hi_r [2];
  logic [PL_W-1:0]       s1_lo_r [2];
  logic                  s1_neg_r [2];
  logic [PL_W:0]         rnd   [2];
  logic [R_W-1:0]        r_full [2];
  logic [R_W-FRAC_W-1:0] r_int [2];
  logic [D_W-1:0]        lim   [2];
  logic [D_W-1:0]        d_nxt [2];
  logic                  clip  [2];
  logic [D_W-1:0]        s2_d_r [2];
  logic [SQ_W-1:0]       s3_sq_r [2];
  logic [SQ_W-1:0]       s4_ssq_r;

  // accumulator and output register
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic             sat_seen_r, sat_seen_nxt;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_clip;
  logic             sat_now;
  logic             out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0] out_value_r;
  logic             out_sat_r;

  // whole pipeline holds while a result waits on a stalled consumer
  assign en  = ~(out_valid_r & out_stall);
  assign pop = en & q_stat.not_empty;

  assign t_in[0] = head.t_re;
  assign t_in[1] = head.t_im;

  // stage 1: magnitude split into high and low parts, times scale
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      mag[i] = t_in[i][T_W-1] ? T_W'(-t_in[i]) : T_W'(t_in[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        s1_hi_r[i]  <= mag[i][T_W-1:FRAC_W] * scale;
        s1_lo_r[i]  <= mag[i][FRAC_W-1:0] * scale;
        s1_neg_r[i] <= t_in[i][T_W-1];
      end
      s1_last_r <= head.last;
    end
  end

  // stage 2: round to nearest, ties away from zero, and clip
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rnd[i]    = {1'b0, s1_lo_r[i]} + ROUND_K;
      r_full[i] = {1'b0, s1_hi_r[i]} + R_W'(rnd[i] >> FRAC_W);
      r_int[i]  = r_full[i][R_W-1:FRAC_W];
      lim[i]    = s1_neg_r[i] ? D_NEG : D_POS;
      clip[i]   = r_int[i] > (R_W - FRAC_W)'(lim[i]);
      d_nxt[i]  = clip[i] ? lim[i] : r_int[i][D_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        s2_d_r[i] <= d_nxt[i];
      end
      s2_sat_r  <= clip[0] | clip[1];
      s2_last_r <= s1_last_r;
    end
  end

  // stage 3: squares
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        s3_sq_r[i] <= s2_d_r[i] * s2_d_r[i];
      end
      s3_sat_r  <= s2_sat_r;
      s3_last_r <= s2_last_r;
    end
  end

  // stage 4: sum of the two squares, at most 2^47
  always_ff @(posedge clk) begin
    if (en) begin
      s4_ssq_r  <= s3_sq_r[0] + s3_sq_r[1];
      s4_sat_r  <= s3_sat_r;
      s4_last_r <= s3_last_r;
    end
  end

  // stage 5: saturating accumulate, emit and clear on the last bin
  always_comb begin
    sum_wide      = {1'b0, sum_r} + {1'b0, SUM_W'(s4_ssq_r)};
    sum_clip      = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    sat_now       = sat_seen_r | s4_sat_r | sum_wide[SUM_W];
    sum_nxt       = sum_r;
    sat_seen_nxt  = sat_seen_r;
    out_valid_nxt = out_valid_r & out_stall;
    if (en && s4_v_r) begin
      if (s4_last_r) begin
        sum_nxt       = '0;
        sat_seen_nxt  = 1'b0;
        out_valid_nxt = 1'b1;
      end else begin
        sum_nxt      = sum_clip;
        sat_seen_nxt = sat_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      sum_r       <= '0;
      sat_seen_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        s1_v_r <= q_stat.not_empty;
        s2_v_r <= s1_v_r;
        s3_v_r <= s2_v_r;
        s4_v_r <= s3_v_r;
      end
      sum_r       <= sum_nxt;
      sat_seen_r  <= sat_seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (en && s4_v_r && s4_last_r) begin
      out_value_r <= sum_clip;
      out_sat_r   <= sat_now;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_chisq_value = out_value_r;
  assign out_saturated   = out_sat_r;

endmodule

[tb/sv/chisq_check_pkg.sv]
// ----------------------------------------------------------------------------
// chisq_check_pkg
// Expected-value tracking for the chi-squared veto accumulator bench: keeps
// its own copy of the registers and the running sum, predicts each emitted
// sum and compares it with what the block delivers.
// ----------------------------------------------------------------------------
package chisq_check_pkg;

  import cva_pkg::*;

  localparam logic [63:0] SUM_CEIL = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] DEV_POS_LIM = 64'd8388607;
  localparam logic [63:0] DEV_NEG_LIM = 64'd8388608;

  typedef struct {
    logic [SUM_W-1:0] value;
    logic             sat;
  } chisq_sum_t;

  class chisq_tracker;
    logic [SCALE_W-1:0] scale;
    logic [INV_W-1:0]   inv;
    logic [63:0]        acc;
    logic               acc_sat;
    chisq_sum_t         expected_sums[$];
    int                 errors;
    int                 bins_seen;
    int                 sums_checked;
    int                 sat_sums;

    function new();
      scale        = SCALE_RST;
      inv          = INV_RST;
      acc          = '0;
      acc_sat      = 1'b0;
      errors       = 0;
      bins_seen    = 0;
      sums_checked = 0;
      sat_sums     = 0;
    endfunction

    // unmapped indexes leave both registers alone
    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SCALE: scale = data[SCALE_W-1:0];
        REG_INV:   inv = data[INV_W-1:0];
        default: ;
      endcase
    endfunction

    // |round(scale * (bin * 2^16 - full * inv) / 2^32)|, clipped to the 24-bit signed range
    function logic [63:0] deviation_mag(logic signed [SMP_W-1:0] full,
                                        logic signed [SMP_W-1:0] bin, output logic clipped);
      longint      diff;
      logic        neg;
      logic [63:0] mag;
      logic [63:0] hi;
      logic [63:0] lo;
      logic [63:0] rnd;
      logic [63:0] lim;
      diff = longint'(bin) * 64'sd65536 - longint'(full) * longint'({1'b0, inv});
      neg = diff < 0;
      mag = neg ? 64'(-diff) : 64'(diff);
      hi = mag >> FRAC_W;
      lo = mag & 64'hFFFF;
      rnd = (hi * 64'(scale) + ((lo * 64'(scale) + 64'h8000_0000) >> 16)) >> 16;
      lim = neg ? DEV_NEG_LIM : DEV_POS_LIM;
      clipped = 1'b0;
      if (rnd > lim) begin
        rnd = lim;
        clipped = 1'b1;
      end
      return rnd;
    endfunction

    // accepted bin: fold it into the sum, queue a result on the last bin
    function void note_bin(logic signed [SMP_W-1:0] full_re, logic signed [SMP_W-1:0] full_im,
                           logic signed [SMP_W-1:0] bin_re, logic signed [SMP_W-1:0] bin_im,
                           logic last);
      logic [63:0] dev_re;
      logic [63:0] dev_im;
      logic [63:0] total;
      logic        clip_re;
      logic        clip_im;
      chisq_sum_t  rec;
      bins_seen++;
      dev_re = deviation_mag(full_re, bin_re, clip_re);
      dev_im = deviation_mag(full_im, bin_im, clip_im);
      total = acc + dev_re * dev_re + dev_im * dev_im;
      if (total > SUM_CEIL) begin
        total = SUM_CEIL;
        acc_sat = 1'b1;
      end
      if (clip_re || clip_im)
        acc_sat = 1'b1;
      acc = total;
      if (last) begin
        rec.value = acc[SUM_W-1:0];
        rec.sat = acc_sat;
        expected_sums.push_back(rec);
        acc = '0;
        acc_sat = 1'b0;
      end
    endfunction

    // delivered result against the oldest expectation
    function void check_sum(logic [SUM_W-1:0] value, logic sat, longint at_ns);
      chisq_sum_t exp_rec;
      if (expected_sums.size() == 0) begin
        $display("[%0t ns] result with nothing expected: chisq_value=%0d saturated=%0b",
                 at_ns, value, sat);
        errors++;
        return;
      end
      exp_rec = expected_sums.pop_front();
      sums_checked++;
      if (exp_rec.sat)
        sat_sums++;
      if (value !== exp_rec.value) begin
        $display("[%0t ns] chisq_value mismatch: expected %0d, actual %0d",
                 at_ns, exp_rec.value, value);
        errors++;
      end
      if (sat !== exp_rec.sat) begin
        $display("[%0t ns] saturated mismatch: expected %0b, actual %0b",
                 at_ns, exp_rec.sat, sat);
        errors++;
      end
    endfunction
  endclass

endpackage

[tb/sv/tb_chisq_veto_accumulator.sv]
// ----------------------------------------------------------------------------
// tb_chisq_veto_accumulator
// Streams bins through the accumulator under a series of register settings
// (zero, unity, full-scale and random), with random gaps and stalls on both
// channels, and checks every emitted sum and saturation flag in order.
// ----------------------------------------------------------------------------
module tb_chisq_veto_accumulator;

  timeunit 1ns;
  timeprecision 1ps;

  import cva_pkg::*;
  import chisq_check_pkg::*;

  localparam int ITEMS_PER_SETTING = 118;
  localparam int SETTING_COUNT     = 8;
  localparam int DRAIN_CYCLES      = 20;
  localparam int HOLD_CYCLES       = 200;
  localparam int IDLE_LIMIT        = 3000;

  localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
  localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = CFG_IDX_W'(3);

  logic clk = 1'b0;
  logic rst_n;

  logic                    in_valid;
  logic                    in_stall;
  logic signed [SMP_W-1:0] in_full_re;
  logic signed [SMP_W-1:0] in_full_im;
  logic signed [SMP_W-1:0] in_bin_re;
  logic signed [SMP_W-1:0] in_bin_im;
  logic                    in_last_bin;
  logic                    out_valid;
  logic                    out_stall;
  logic [SUM_W-1:0]        out_chisq_value;
  logic                    out_saturated;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  chisq_tracker tracker = new();
  int           holds_asked = 0;
  int           quiet_cycles = 0;
  int           reg_writes = 0;

  chisq_veto_accumulator uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_full_re      (in_full_re),
    .in_full_im      (in_full_im),
    .in_bin_re       (in_bin_re),
    .in_bin_im       (in_bin_im),
    .in_last_bin     (in_last_bin),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_chisq_value (out_chisq_value),
    .out_saturated   (out_saturated),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int unsigned sel = $urandom_range(99);
    if (sel < 60)
      return 0;
    else if (sel < 92)
      return $urandom_range(1, 3);
    else
      return $urandom_range(10, 40);
  endfunction

  function automatic int pick_bin_count();
    int unsigned sel = $urandom_range(99);
    if (sel < 70)
      return $urandom_range(1, 8);
    else if (sel < 95)
      return $urandom_range(9, 24);
    else
      return $urandom_range(25, 64);
  endfunction

  // extremes, small values near zero, or any 24-bit pattern
  function automatic logic signed [SMP_W-1:0] pick_sample();
    int unsigned sel = $urandom_range(99);
    int          v;
    if (sel < 8) begin
      case ($urandom_range(3))
        0: return SMP_MAX;
        1: return SMP_MIN;
        2: return '0;
        default: return '1;
      endcase
    end else if (sel < 50) begin
      v = int'($urandom_range(4095)) - 2048;
      return SMP_W'(v);
    end
    return SMP_W'($urandom);
  endfunction

  // one bin transfer; valid stays up for the caller to reuse or lower
  task automatic send_bin(input logic signed [SMP_W-1:0] fr, input logic signed [SMP_W-1:0] fi,
                          input logic signed [SMP_W-1:0] br, input logic signed [SMP_W-1:0] bi,
                          input logic last);
    in_valid    <= 1'b1;
    in_full_re  <= fr;
    in_full_im  <= fi;
    in_bin_re   <= br;
    in_bin_im   <= bi;
    in_last_bin <= last;
    do @(posedge clk); while (in_stall);
    tracker.note_bin(fr, fi, br, bi, last);
  endtask

  // register write; valid is left high for back-to-back writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_register(idx, data);
    reg_writes++;
  endtask

  task automatic program_regs(input logic [SCALE_W-1:0] scale_val,
                              input logic [INV_W-1:0] inv_val);
    write_reg(REG_SCALE, scale_val);
    write_reg(REG_INV, {8'($urandom), inv_val});
    write_reg(REG_UNMAPPED_LO, CFG_DATA_W'($urandom));
    write_reg(REG_UNMAPPED_HI, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // sender pause: every expected sum out, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.expected_sums.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // random samples of random length; the first burst_count bins are
  // single-bin samples sent back to back
  task automatic run_random(input int count, input int burst_count);
    int bins_left = 0;
    int calm_left = 0;
    int gap;
    bit calm = 1'b0;
    for (int k = 0; k < count; k++) begin
      if (calm_left == 0) begin
        calm = ($urandom_range(3) == 0);
        calm_left = $urandom_range(20, 80);
      end
      calm_left--;
      gap = (calm || k < burst_count) ? 0 : pick_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      if (bins_left == 0)
        bins_left = (k < burst_count) ? 1 : pick_bin_count();
      send_bin(pick_sample(), pick_sample(), pick_sample(), pick_sample(), bins_left == 1);
      bins_left--;
    end
  endtask

  // extremes, rounding ties, both kinds of saturation, multi-bin samples
  task automatic run_directed();
    send_bin('0, '0, '0, '0, 1'b1);
    send_bin(24'sd8, -24'sd8, '0, '0, 1'b1);
    send_bin(SMP_MIN, SMP_MAX, SMP_MAX, SMP_MIN, 1'b1);
    send_bin(24'sd16, -24'sd32, 24'sd3, -24'sd5, 1'b1);
    send_bin(SMP_MIN, SMP_MAX, SMP_MAX, SMP_MIN, 1'b0);
    send_bin(SMP_MIN, SMP_MAX, SMP_MAX, SMP_MIN, 1'b0);
    send_bin(SMP_MIN, SMP_MAX, SMP_MAX, SMP_MIN, 1'b1);
    send_bin(24'sd100, 24'sd200, 24'sd7, -24'sd9, 1'b0);
    send_bin(-24'sd100, -24'sd200, -24'sd7, 24'sd9, 1'b0);
    send_bin(SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX, 1'b0);
    send_bin(SMP_MIN, SMP_MIN, SMP_MIN, SMP_MIN, 1'b1);
    send_bin('1, '1, '1, '1, 1'b1);
    send_bin(24'sd24, -24'sd24, -24'sd1, 24'sd1, 1'b1);
  endtask

  // result side: checks transfers and stalls at random, with calm stretches
  // and one long hold-off per request from the stimulus
  initial begin : result_sink
    int stall_left;
    int mode_left;
    int holds_done;
    bit calm;
    stall_left = 0;
    mode_left  = 0;
    holds_done = 0;
    calm       = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        tracker.check_sum(out_chisq_value, out_saturated, $time);
      if (holds_asked != holds_done) begin
        holds_done++;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0) begin
        if (mode_left == 0) begin
          calm = ($urandom_range(3) == 0);
          mode_left = $urandom_range(30, 200);
        end
        mode_left--;
        if (!calm)
          stall_left = pick_gap();
      end
      out_stall <= (stall_left > 0);
      if (stall_left > 0)
        stall_left--;
    end
  end

  // watchdog on cycles with no transfer on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[%0t ns] no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin : stimulus
    logic [SCALE_W-1:0] scale_val;
    logic [INV_W-1:0]   inv_val;
    int                 burst;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_full_re  <= '0;
    in_full_im  <= '0;
    in_bin_re   <= '0;
    in_bin_im   <= '0;
    in_last_bin <= 1'b0;
    cfg_valid   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values of the registers first
    run_directed();

    for (int s = 0; s < SETTING_COUNT; s++) begin
      settle();
      burst = 0;
      case (s)
        0: begin scale_val = '0; inv_val = INV_RST; end
        1: begin scale_val = '1; inv_val = '0; end
        2: begin scale_val = SCALE_RST; inv_val = '1; end
        3: begin scale_val = SCALE_W'(1); inv_val = INV_W'(1); end
        4: begin
          scale_val = SCALE_W'($urandom_range(1 << 12, 1 << 18));
          inv_val = INV_W'($urandom);
        end
        5: begin scale_val = SCALE_W'($urandom); inv_val = INV_W'($urandom); end
        6: begin
          // block fills while the result side holds off
          scale_val = SCALE_RST;
          inv_val = INV_RST;
          burst = 60;
        end
        default: begin scale_val = SCALE_RST; inv_val = '0; end
      endcase
      program_regs(scale_val, inv_val);
      if (burst > 0)
        holds_asked <= holds_asked + 1;
      if (s == 3) begin
        run_random(ITEMS_PER_SETTING / 2, 0);
        settle();
        run_random(ITEMS_PER_SETTING - ITEMS_PER_SETTING / 2, 0);
      end else begin
        run_random(ITEMS_PER_SETTING, burst);
      end
    end

    settle();
    $display("covered %0d bins and %0d chi-squared sums (%0d saturated)",
             tracker.bins_seen, tracker.sums_checked, tracker.sat_sums);
    $display("over %0d register settings with %0d register writes",
             SETTING_COUNT + 1, reg_writes);
    if (tracker.expected_sums.size() != 0)
      $display("%0d expected sums never arrived", tracker.expected_sums.size());
    if (tracker.errors == 0 && tracker.expected_sums.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/cva_pkg.sv
rtl/cva_front.sv
rtl/cva_queue.sv
rtl/cva_back.sv
rtl/chisq_veto_accumulator.sv
tb/sv/chisq_check_pkg.sv
tb/sv/tb_chisq_veto_accumulator.sv
